// ===== design/ssmm_pkg.sv =====
// ssmm_pkg: shared widths, types and the sequencer state encoding for the
// sample sorter. No dependencies; compile first.
package ssmm_pkg;

  localparam int DATA_W = 32;
  localparam int RANK_W = 6;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [RANK_W-1:0] rank_t;

  // One-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CMP  = 9'b000000010,
    S_PUT  = 9'b000000100,
    S_ST0  = 9'b000001000,
    S_ST1  = 9'b000010000,
    S_ST2  = 9'b000100000,
    S_ST3  = 9'b001000000,
    S_ERD  = 9'b010000000,
    S_ELD  = 9'b100000000
  } ssmm_state_t;

  // Sequencer to output stage: load one result word
  typedef struct packed {
    logic  load;
    rank_t rank;
    logic  last;
    data_t min_value;
    data_t median_value;
    data_t max_value;
  } ssmm_emit_t;

endpackage

// ===== design/ssmm_if.sv =====
// ssmm_if: valid/ready channel interfaces for sample input and sorted output.
// Depends on ssmm_pkg.
interface ssmm_in_if import ssmm_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface ssmm_out_if import ssmm_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  rank_t rank;
  logic  last_of_run;
  data_t min_value;
  data_t median_value;
  data_t max_value;

  modport source (
    output valid, output sorted_value, output rank, output last_of_run,
    output min_value, output median_value, output max_value, input ready
  );
  modport sink (
    input valid, input sorted_value, input rank, input last_of_run,
    input min_value, input median_value, input max_value, output ready
  );
endinterface

// ===== design/ssmm_ram.sv =====
// ssmm_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module ssmm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ssmm_seq.sv =====
// ssmm_seq: insertion and readout sequencer. Drives the sample RAM and hands
// result words to the output stage. Depends on ssmm_pkg.
module ssmm_seq import ssmm_pkg::*; #(
  parameter int RUN_LENGTH = 16,
  parameter int ADDR_W     = (RUN_LENGTH > 1) ? $clog2(RUN_LENGTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  data_t             in_data,
  output logic              in_ready,
  input  logic              out_free,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output data_t             ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  data_t             ram_rdata,
  output ssmm_emit_t        emit
);

  localparam logic [ADDR_W-1:0] LastIdx = ADDR_W'(RUN_LENGTH - 1);
  localparam logic [ADDR_W-1:0] MidIdx  = ADDR_W'(RUN_LENGTH / 2);

  ssmm_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  data_t             v_r, v_nxt;
  data_t             min_r, min_nxt;
  data_t             med_r, med_nxt;
  data_t             max_r, max_nxt;
  logic              run_done;

  assign run_done = (fill_r == LastIdx);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    v_nxt     = v_r;
    min_nxt   = min_r;
    med_nxt   = med_r;
    max_nxt   = max_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = v_r;
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    emit              = '0;
    emit.rank         = RANK_W'(idx_r);
    emit.last         = (idx_r == LastIdx);
    emit.min_value    = min_r;
    emit.median_value = med_r;
    emit.max_value    = max_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt = in_data;
          if (fill_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_PUT;
          end else begin
            pos_nxt   = fill_r;
            ram_re    = 1'b1;
            ram_raddr = fill_r - 1'b1;
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        // read data is the entry just below pos
        ram_we = 1'b1;
        if (ram_rdata > v_r) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - 1'b1;
          if (pos_r != ADDR_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = (pos_r - 1'b1) - 1'b1;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          if (run_done) begin
            fill_nxt  = '0;
            state_nxt = S_ST0;
          end else begin
            fill_nxt  = fill_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_PUT: begin
        ram_we = 1'b1;
        if (run_done) begin
          fill_nxt  = '0;
          state_nxt = S_ST0;
        end else begin
          fill_nxt  = fill_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ST0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = S_ST1;
      end
      S_ST1: begin
        min_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = MidIdx;
        state_nxt = S_ST2;
      end
      S_ST2: begin
        med_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = LastIdx;
        state_nxt = S_ST3;
      end
      S_ST3: begin
        max_nxt   = ram_rdata;
        idx_nxt   = '0;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        if (out_free) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r;
          state_nxt = S_ELD;
        end
      end
      S_ELD: begin
        emit.load = 1'b1;
        if (idx_r == LastIdx) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    v_r   <= v_nxt;
    min_r <= min_nxt;
    med_r <= med_nxt;
    max_r <= max_nxt;
  end

  // a compare step always has a stored entry below the insertion point
  a_cmp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> pos_r != '0)
    else $error("compare step with insertion point at zero");

  // the store is written only while a sample is being inserted
  a_we_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CMP || state_r == S_PUT))
    else $error("store written outside insertion");

  // a result word is loaded only into a free output stage
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> out_free)
    else $error("result loaded over a waiting word");

  // fill count stays below the run length
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LastIdx)
    else $error("fill count out of range");

  // input is taken only between runs, never during readout
  a_no_take_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERD || state_r == S_ELD) |-> !in_ready)
    else $error("input ready during readout");

endmodule

// ===== design/sample_sort_min_median_max.sv =====
// sample_sort_min_median_max: top level of the run sorter with min, median
// and max. Depends on ssmm_pkg, ssmm_if, ssmm_ram and ssmm_seq.
//
// Usage
//   in_ch  : one 32-bit unsigned sample per word (valid/ready).
//   out_ch : after the RUN_LENGTH-th sample of a run, RUN_LENGTH words in
//            ascending order, each with its rank, a last-of-run flag on the
//            final word and the run's min, median (sorted entry
//            RUN_LENGTH/2) and max. Other samples produce no word.
// Operation
//   Inserting a sample into a run that already holds n samples shifts
//   up its s larger entries (s <= n) one slot each, then writes the sample;
//   the shift walk is bounded by the single read and single write port of
//   the sample RAM, one entry per cycle. Only one sample is in flight.
//   Readout fetches min, median and max (S_ST0..S_ST3), then per word a RAM
//   read (S_ERD, held until out_free) and an output register load (S_ELD).
// Reset and stall
//   Reset clears the fill count and the sequencer; RAM contents are left
//   as they are, since an entry is always written before it is read.
//   A stalled receiver holds the output word and the readout waits; the
//   final word of a run may wait while the next run's samples are taken.
module sample_sort_min_median_max import ssmm_pkg::*; #(
  parameter int RUN_LENGTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ssmm_in_if.sink   in_ch,
  ssmm_out_if.source out_ch
);

  localparam int AddrW = (RUN_LENGTH > 1) ? $clog2(RUN_LENGTH) : 1;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  data_t            ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  data_t            ram_rdata;
  ssmm_emit_t       emit;
  logic             out_free;

  // output register
  logic  out_valid_r;
  data_t sorted_r;
  rank_t rank_r;
  logic  last_r;
  data_t min_r;
  data_t med_r;
  data_t max_r;

  // the output register can take a word when empty or draining this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  ssmm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RUN_LENGTH),
    .ADDR_W(AddrW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ssmm_seq #(
    .RUN_LENGTH(RUN_LENGTH),
    .ADDR_W    (AddrW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.sample_value),
    .in_ready (in_ch.ready),
    .out_free (out_free),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .emit     (emit)
  );

  // hold the word while the receiver stalls, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: sorted value comes straight from the RAM read register
  always_ff @(posedge clk) begin
    if (emit.load) begin
      sorted_r <= ram_rdata;
      rank_r   <= emit.rank;
      last_r   <= emit.last;
      min_r    <= emit.min_value;
      med_r    <= emit.median_value;
      max_r    <= emit.max_value;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = sorted_r;
  assign out_ch.rank         = rank_r;
  assign out_ch.last_of_run  = last_r;
  assign out_ch.min_value    = min_r;
  assign out_ch.median_value = med_r;
  assign out_ch.max_value    = max_r;

endmodule

// ===== tb/sv/sample_sort_min_median_max_tb.sv =====
`timescale 1ns / 1ps
// sample_sort_min_median_max_tb: self-checking bench for the run sorter with
// min, median and max. Depends on ssmm_pkg, ssmm_if and the sorter RTL.
module sample_sort_min_median_max_tb;
  import ssmm_pkg::*;

  localparam int RUN_LENGTH  = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 2 * RUN_LENGTH + 20;

  // Shapes of a run of samples; each stresses the insertion walk differently
  typedef enum int {
    RUN_RANDOM,
    RUN_ASCENDING,
    RUN_DESCENDING,
    RUN_EQUAL,
    RUN_FEW_VALUES,
    RUN_NEAR_EXTREMES
  } run_shape_t;

  // One expected output word
  typedef struct packed {
    data_t sorted_value;
    rank_t rank;
    logic  last_of_run;
    data_t min_value;
    data_t median_value;
    data_t max_value;
  } sorted_word_t;

  logic clk;
  logic rst_n;

  ssmm_in_if  in_ch ();
  ssmm_out_if out_ch ();

  sample_sort_min_median_max #(
    .RUN_LENGTH(RUN_LENGTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Local sorted copy of the current run and the words still owed by the block
  data_t        run_store [RUN_LENGTH];
  int           run_fill;
  sorted_word_t sorted_words_q [$];

  int  err_count;
  int  cycle_count;
  int  ready_hold;
  bit  source_gaps;
  bit  sink_stalls;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(3, 1);
    else
      return $urandom_range(40, 8);
  endfunction

  // Insert one accepted sample into the sorted run; on the sample that
  // completes the run, queue the whole ascending readout.
  function automatic void insert_sample(data_t v);
    int           pos;
    int           k;
    sorted_word_t w;
    pos = run_fill;
    // shift larger entries up one slot; equal entries stay below the new one
    while (pos > 0 && run_store[pos-1] > v) begin
      run_store[pos] = run_store[pos-1];
      pos--;
    end
    run_store[pos] = v;
    run_fill++;
    if (run_fill == RUN_LENGTH) begin
      for (k = 0; k < RUN_LENGTH; k++) begin
        w.sorted_value = run_store[k];
        w.rank         = rank_t'(k);
        w.last_of_run  = (k == RUN_LENGTH - 1);
        w.min_value    = run_store[0];
        w.median_value = run_store[RUN_LENGTH/2];
        w.max_value    = run_store[RUN_LENGTH-1];
        sorted_words_q.push_back(w);
      end
      run_fill = 0;
    end
  endfunction

  // Offer one sample and hold it until the block takes it. Valid is left
  // high on return, so a following word with no gap goes out back to back.
  task automatic send_sample(data_t v);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    insert_sample(v);
  endtask

  // Drop valid and hold off until every owed word has been received
  task automatic wait_for_readout();
    in_ch.valid <= 1'b0;
    while (sorted_words_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_run(run_shape_t shape);
    data_t base;
    data_t v;
    int    k;
    base = $urandom;
    for (k = 0; k < RUN_LENGTH; k++) begin
      case (shape)
        RUN_ASCENDING:  v = base + k;
        RUN_DESCENDING: v = base - k;
        RUN_EQUAL:      v = base;
        RUN_FEW_VALUES: v = {$urandom_range(1, 0) == 1, 29'd0, 2'($urandom_range(3, 0))};
        RUN_NEAR_EXTREMES: begin
          v = data_t'($urandom_range(2, 0));
          if ($urandom_range(1, 0) == 1)
            v = ~v;
        end
        default:        v = $urandom;
      endcase
      send_sample(v);
    end
  endtask

  // Extremes, duplicates of both extremes and a descending tail that makes
  // the last insertions walk across most of the store.
  task automatic test_directed_run();
    data_t directed_vals [RUN_LENGTH] = '{
      32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0001,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
      32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000
    };
    int k;
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (k = 0; k < RUN_LENGTH; k++)
      send_sample(directed_vals[k]);
    wait_for_readout();
  endtask

  // One run of each shape with both sides idling at random
  task automatic test_shaped_runs();
    run_shape_t shape;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    shape = shape.first();
    do begin
      send_run(shape);
      shape = shape.next();
    end while (shape != shape.first());
  endtask

  // Let the block empty completely before the next run starts
  task automatic test_drained_pause();
    send_run(RUN_RANDOM);
    wait_for_readout();
    send_run(RUN_DESCENDING);
  endtask

  // Random shapes, each run under a random choice of idling on either side
  task automatic test_random_runs();
    int k;
    for (k = 0; k < 8; k++) begin
      source_gaps = $urandom_range(2, 0) != 0;
      sink_stalls = $urandom_range(2, 0) != 0;
      if ($urandom_range(1, 0) == 1)
        send_run(RUN_RANDOM);
      else
        send_run(run_shape_t'($urandom_range(RUN_NEAR_EXTREMES, RUN_RANDOM)));
    end
  endtask

  // Receiver: with stalls on, hold ready at a random level for a random stretch; else keep it high
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!sink_stalls) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= $urandom_range(2, 0) != 0;
      ready_hold   <= pick_gap();
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      err_count++;
    end
  endtask

  // Compare every received word with the oldest owed one
  always @(posedge clk) begin
    sorted_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_words_q.size() == 0) begin
        $display("%0t: unexpected word, sorted_value %h rank %0d", $time,
                 out_ch.sorted_value, out_ch.rank);
        err_count++;
      end else begin
        w = sorted_words_q.pop_front();
        check_field("sorted_value", w.sorted_value, out_ch.sorted_value);
        check_field("rank", 32'(w.rank), 32'(out_ch.rank));
        check_field("last_of_run", 32'(w.last_of_run), 32'(out_ch.last_of_run));
        check_field("min_value", w.min_value, out_ch.min_value);
        check_field("median_value", w.median_value, out_ch.median_value);
        check_field("max_value", w.max_value, out_ch.max_value);
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    run_fill    = 0;
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_run();
    test_shaped_runs();
    test_drained_pause();
    test_random_runs();

    // Drain the owed words, then watch a while for stray ones
    wait_for_readout();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && sorted_words_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ssmm_pkg.sv
design/ssmm_if.sv
design/ssmm_ram.sv
design/ssmm_seq.sv
design/sample_sort_min_median_max.sv
tb/sv/sample_sort_min_median_max_tb.sv
